### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/scmix_pkg.sv
// ----------------------------------------------------------------------------
// scmix_pkg
// Widths and constants shared by the soft-clip sample mixer files.
// ----------------------------------------------------------------------------
package scmix_pkg;

  // Q1.15 sample and reported count widths
  localparam int SAMPLE_W        = 16;
  localparam int COUNT_OUT_W     = 7;
  localparam int FRAC_SH         = 15;

  // Default source limit per slot
  localparam int MAX_SOURCES_DEF = 64;

  // Q0.30 working format: values up to and including 1.0
  localparam int           Q30_W    = 31;
  localparam logic [30:0]  Q30_ONE  = 31'h4000_0000;
  localparam logic [31:0]  MAG_RND  = 32'h0000_4000;

  // Saturation bounds of the output magnitude
  localparam logic [16:0]  MAG_POS_MAX = 17'd32767;
  localparam logic [16:0]  MAG_NEG_MAX = 17'd32768;

endpackage

### rtl/core/soft_clip_sample_mixer_unit.sv
// ----------------------------------------------------------------------------
// soft_clip_sample_mixer_unit
// Sums source samples of one output slot and emits the soft-clipped mix.
// ----------------------------------------------------------------------------
// Source beats are taken one per cycle while the unit is accumulating. A
// beat that closes a slot (present low, or last_source high) holds off further
// source beats until the result is in the output register. A slot of zero or
// one source goes straight there; otherwise the serial divider forms the
// average one bit per cycle over a dividend of DVD_W = 15 +
// $clog2(MAX_SOURCES + 1) + 15 bits (37 at the default), and the bit-serial
// multiplier then forms the M = floor(log2 n) + popcount(n >> 1) Q0.30
// products of the power-by-squaring, one after another. The hold-off grows
// while an earlier result still waits in the output register. The output
// register lets the next slot accumulate while a result waits to be taken.
module soft_clip_sample_mixer_unit #(
  parameter int MAX_SOURCES = scmix_pkg::MAX_SOURCES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  src_valid,
  output logic                                  src_stall,
  input  logic signed [scmix_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                  present,
  input  logic                                  last_source,
  input  logic                                  end_of_buffer,
  output logic                                  mix_valid,
  input  logic                                  mix_stall,
  output logic signed [scmix_pkg::SAMPLE_W-1:0] mixed_sample,
  output logic [scmix_pkg::COUNT_OUT_W-1:0]     source_count,
  output logic                                  buffer_last
);

  localparam int SAMPLE_W    = scmix_pkg::SAMPLE_W;
  localparam int COUNT_OUT_W = scmix_pkg::COUNT_OUT_W;
  localparam int Q30_W       = scmix_pkg::Q30_W;
  localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
  localparam int SUM_W       = SAMPLE_W + CNT_W;
  localparam int MAG_W       = SUM_W - 1;
  localparam int DVD_W       = MAG_W + scmix_pkg::FRAC_SH;

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                  state;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        n_r;
  logic [CNT_W-1:0]        iter;
  logic                    neg_r;
  logic                    eob_r;
  logic                    op_sq;
  logic                    mul_start;
  logic [SAMPLE_W-1:0]     res;
  logic [Q30_W-1:0]        base;
  logic [Q30_W-1:0]        acc;

  logic                    src_accept;
  logic                    take;
  logic                    close;
  logic signed [SUM_W-1:0] sum_fin;
  logic [CNT_W-1:0]        cnt_fin;
  logic [SUM_W-1:0]        sum_abs;
  logic                    div_start;
  logic                    div_done;
  logic [Q30_W-1:0]        quo;
  logic [Q30_W-1:0]        dval;
  logic                    mul_done;
  logic [Q30_W-1:0]        prod;
  logic [Q30_W-1:0]        mul_a;
  logic [CNT_W-1:0]        iter_shr;
  logic [SAMPLE_W-1:0]     fin_res;
  logic [Q30_W-1:0]        r_q30;
  logic [31:0]             r_rnd;
  logic [16:0]             mag;

  // Source side: accumulate, clamp the count, detect slot close
  assign src_stall  = (state != ST_ACC);
  assign src_accept = src_valid && !src_stall;

  always_comb begin
    take    = present && (count < CNT_W'(MAX_SOURCES));
    close   = !present || last_source;
    sum_fin = take ? (sum + SUM_W'(sample_value)) : sum;
    cnt_fin = take ? (count + 1'b1) : count;
    sum_abs = sum_fin[SUM_W-1] ? SUM_W'(-sum_fin) : SUM_W'(sum_fin);
  end

  assign div_start = src_accept && close && (cnt_fin > CNT_W'(1));

  // |avg| in Q0.30 = |sum| * 2^15 / n
  scmix_serial_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W),
    .QUO_W (Q30_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_abs[MAG_W-1:0], {scmix_pkg::FRAC_SH{1'b0}}}),
    .divisor  (cnt_fin),
    .done     (div_done),
    .quotient (quo)
  );

  // Power by squaring: either square the base or fold it into the product
  assign mul_a = op_sq ? base : acc;

  scmix_serial_mul #(
    .W (Q30_W)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .a        (mul_a),
    .b        (base),
    .done     (mul_done),
    .prod_rnd (prod)
  );

  // Final soft-clip: 1 - p, back to Q1.15 rounding half up, sign, saturate
  always_comb begin
    dval     = scmix_pkg::Q30_ONE - quo;
    iter_shr = iter >> 1;
    r_q30    = scmix_pkg::Q30_ONE - prod;
    r_rnd    = {1'b0, r_q30} + scmix_pkg::MAG_RND;
    mag      = r_rnd[31:15];
    if (neg_r) begin
      if (mag > scmix_pkg::MAG_NEG_MAX) begin
        fin_res = SAMPLE_W'(-scmix_pkg::MAG_NEG_MAX);
      end else begin
        fin_res = SAMPLE_W'(-mag);
      end
    end else begin
      if (mag > scmix_pkg::MAG_POS_MAX) begin
        fin_res = SAMPLE_W'(scmix_pkg::MAG_POS_MAX);
      end else begin
        fin_res = SAMPLE_W'(mag);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      sum       <= '0;
      count     <= '0;
      mul_start <= 1'b0;
      mix_valid <= 1'b0;
    end else begin
      // a taken result beat empties the output register unless a new one loads
      if (mix_valid && !mix_stall && (state != ST_DONE)) begin
        mix_valid <= 1'b0;
      end
      case (state)
        ST_ACC: begin
          mul_start <= 1'b0;
          if (src_accept) begin
            if (close) begin
              sum   <= '0;
              count <= '0;
              n_r   <= cnt_fin;
              neg_r <= sum_fin[SUM_W-1];
              eob_r <= end_of_buffer;
              if (cnt_fin == '0) begin
                res   <= '0;
                state <= ST_DONE;
              end else if (cnt_fin == CNT_W'(1)) begin
                res   <= sum_fin[SAMPLE_W-1:0];
                state <= ST_DONE;
              end else begin
                state <= ST_DIV;
              end
            end else begin
              sum   <= sum_fin;
              count <= cnt_fin;
            end
          end
        end
        ST_DIV: begin
          mul_start <= div_done;
          if (div_done) begin
            base  <= dval;
            acc   <= n_r[0] ? dval : scmix_pkg::Q30_ONE;
            iter  <= n_r >> 1;
            op_sq <= 1'b1;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            if (op_sq) begin
              base      <= prod;
              mul_start <= 1'b1;
              if (iter[0]) begin
                op_sq <= 1'b0;
              end else begin
                iter <= iter_shr;
              end
            end else begin
              acc  <= prod;
              iter <= iter_shr;
              if (iter_shr == '0) begin
                res       <= fin_res;
                mul_start <= 1'b0;
                state     <= ST_DONE;
              end else begin
                op_sq     <= 1'b1;
                mul_start <= 1'b1;
              end
            end
          end else begin
            mul_start <= 1'b0;
          end
        end
        ST_DONE: begin
          mul_start <= 1'b0;
          if (!mix_valid || !mix_stall) begin
            mix_valid    <= 1'b1;
            mixed_sample <= res;
            source_count <= COUNT_OUT_W'(n_r);
            buffer_last  <= eob_r;
            state        <= ST_ACC;
          end
        end
        default: begin
          mul_start <= 1'b0;
          state     <= ST_ACC;
        end
      endcase
    end
  end

endmodule

### rtl/core/scmix_serial_div.sv
// ----------------------------------------------------------------------------
// scmix_serial_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module scmix_serial_div #(
  parameter int DVD_W = 37,
  parameter int DVS_W = 7,
  parameter int QUO_W = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W:0]   diff;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  // Dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        dvd  <= {dvd[DVD_W-2:0], qbit};
        rem  <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt  <= cnt - 1'b1;
        // last quotient bit raises done for one cycle
        busy <= (cnt != CNT_W'(1));
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient = dvd[QUO_W-1:0];

endmodule

### rtl/core/scmix_serial_mul.sv
// ----------------------------------------------------------------------------
// scmix_serial_mul
// Shift-add multiplier for Q0.(W-1) fractions, one multiplier bit per cycle,
// result rounded half up back to Q0.(W-1).
// ----------------------------------------------------------------------------
module scmix_serial_mul #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] prod_rnd
);

  localparam int FRAC  = W - 1;
  localparam int CNT_W = $clog2(W + 1);

  logic [2*W-1:0] p;
  logic [CNT_W-1:0] cnt;
  logic           busy;

  logic [W:0]     upper;
  logic [2*W-1:0] rsum;

  // Add a into the high half when the current multiplier bit is set
  always_comb begin
    upper = {1'b0, p[2*W-1:W]} + (p[0] ? {1'b0, a} : '0);
    rsum  = p + ((2*W)'(1) << (FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        p    <= {{W{1'b0}}, b};
        cnt  <= CNT_W'(W);
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy) begin
        p    <= {upper, p[W-1:1]};
        cnt  <= cnt - 1'b1;
        // last multiplier bit raises done for one cycle
        busy <= (cnt != CNT_W'(1));
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign prod_rnd = rsum[FRAC+W-1:FRAC];

endmodule

### rtl/core/scmix_checker.sv
// ----------------------------------------------------------------------------
// scmix_checker
// Port-level checks on the soft-clip sample mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scmix_checker #(
  parameter int MAX_SOURCES = scmix_pkg::MAX_SOURCES_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  src_valid,
  input logic                                  src_stall,
  input logic                                  present,
  input logic                                  last_source,
  input logic                                  mix_valid,
  input logic                                  mix_stall,
  input logic signed [scmix_pkg::SAMPLE_W-1:0] mixed_sample,
  input logic [scmix_pkg::COUNT_OUT_W-1:0]     source_count,
  input logic                                  buffer_last
);

  logic [scmix_pkg::SAMPLE_W+scmix_pkg::COUNT_OUT_W:0] mix_payload;
  logic                                                src_close;
  logic                                                mix_empty;

  assign mix_payload = {mixed_sample, source_count, buffer_last};
  assign src_close   = src_valid && !src_stall && (!present || last_source);
  assign mix_empty   = mix_valid && (source_count == '0) && (MAX_SOURCES < 128);

  // A stalled result beat stays valid
  `ASSERT_NEXT(a_mix_hold, clk, rst, mix_valid && mix_stall, mix_valid)

  // A stalled result beat keeps its payload
  `ASSERT_NEXT(a_mix_stable, clk, rst, mix_valid && mix_stall, $stable(mix_payload))

  // A beat that closes a slot holds off the next source beat
  `ASSERT_NEXT(a_close_stalls, clk, rst, src_close, src_stall)

  // A slot without sources mixes to silence
  `ASSERT_IMPL(a_empty_zero, clk, rst, mix_empty, mixed_sample == '0)

endmodule

bind soft_clip_sample_mixer_unit scmix_checker #(
  .MAX_SOURCES (MAX_SOURCES)
) u_scmix_checker (.*);
